// File: design/photon_packet_imager_core_defines.svh
// ------------------------------------------------------------------------
// photon_packet_imager_core_defines
// assertion macros shared by the imager core modules
// ------------------------------------------------------------------------
`ifndef PHOTON_PACKET_IMAGER_CORE_DEFINES_SVH
`define PHOTON_PACKET_IMAGER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PPI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ppi_pkg.sv
// ------------------------------------------------------------------------
// ppi_pkg
// shared types and constants of the photon packet imager
// ------------------------------------------------------------------------
package ppi_pkg;

    // stream word markers
    localparam logic [7:0] HDR_START   = 8'hFF;
    localparam logic [7:0] SHORT_START = 8'h7F;
    localparam logic [7:0] SHORT_ID    = 8'hFF;

    // packet length counter
    localparam logic [9:0] COUNT_MAX       = 10'd1023;
    localparam logic [9:0] MAX_WORDS_RESET = 10'd104;

    // result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // what a word does once decoded
    typedef enum logic [2:0] {
        K_IGNORE,
        K_READ,
        K_HEADER,
        K_PHOTON,
        K_SHORT
    } t_kind;

    // decoded word traveling down the pipeline
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  source_id;
        logic [11:0] frame;
        logic        src_oor;
        logic        too_long;
        logic [9:0]  x;
        logic [9:0]  y;
    } t_item;

    // one result word
    typedef struct packed {
        logic        frame_checked;
        logic        frame_missed;
        logic [7:0]  source_id;
        logic [11:0] expected_frame;
        logic [11:0] received_frame;
        logic        source_out_of_range;
        logic        packet_too_long;
        logic        packet_ended_short;
        logic [15:0] pixel_count;
    } t_result;

endpackage

// File: design/ppi_in_if.sv
// ------------------------------------------------------------------------
// ppi_in_if
// input word channel: stream words and read-and-clear requests
// ------------------------------------------------------------------------
interface ppi_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] word;
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;

    modport source (output valid, operation, word, pixel_x, pixel_y, input ready);
    modport sink (input valid, operation, word, pixel_x, pixel_y, output ready);
endinterface

// File: design/ppi_cfg_if.sv
// ------------------------------------------------------------------------
// ppi_cfg_if
// configuration write channel for the packet length limit
// ------------------------------------------------------------------------
interface ppi_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] max_packet_words;

    modport source (output valid, max_packet_words, input ready);
    modport sink (input valid, max_packet_words, output ready);
endinterface

// File: design/ppi_out_if.sv
// ------------------------------------------------------------------------
// ppi_out_if
// result word channel
// ------------------------------------------------------------------------
interface ppi_out_if;
    logic        valid;
    logic        ready;
    logic        frame_checked;
    logic        frame_missed;
    logic [7:0]  source_id;
    logic [11:0] expected_frame;
    logic [11:0] received_frame;
    logic        source_out_of_range;
    logic        packet_too_long;
    logic        packet_ended_short;
    logic [15:0] pixel_count;

    modport source (
        output valid, frame_checked, frame_missed, source_id, expected_frame,
               received_frame, source_out_of_range, packet_too_long,
               packet_ended_short, pixel_count,
        input  ready
    );
    modport sink (
        input  valid, frame_checked, frame_missed, source_id, expected_frame,
               received_frame, source_out_of_range, packet_too_long,
               packet_ended_short, pixel_count,
        output ready
    );
endinterface

// File: design/photon_packet_imager_core.sv
// ------------------------------------------------------------------------
// photon_packet_imager_core
// path: decode register, address stages a, b, c, modify stage, result queue
// throughput: one word per cycle while input ready is high; pixel and frame
//   memories take one read and one write-back per cycle, queue holds 8 words
// reset: a clearing pass over max(IMAGE_COLS*IMAGE_ROWS, NUM_SOURCES) words
//   (10000 at default size) zeroes both memories; input ready stays low
// ------------------------------------------------------------------------
module photon_packet_imager_core #(
    parameter int IMAGE_COLS  = 80,
    parameter int IMAGE_ROWS  = 125,
    parameter int NUM_SOURCES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppi_in_if.sink      i_in,
    ppi_cfg_if.sink     i_cfg,
    ppi_out_if.source   o_out
);

    localparam int PIX_DEPTH = IMAGE_COLS * IMAGE_ROWS;
    localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;

    logic                          accept;
    logic                          d_vld;
    ppi_pkg::t_item                d_item;
    logic                          c_vld;
    ppi_pkg::t_item                c_item;
    logic [PIX_AW-1:0]             c_pix_addr;
    logic [1:0]                    addr_occ;
    logic                          clearing;
    logic                          res_vld;
    ppi_pkg::t_result              res;
    logic                          pop;
    logic                          q_valid;
    ppi_pkg::t_result              q_data;
    logic [ppi_pkg::OUTQ_CW-1:0]   q_count;
    logic [4:0]                    used;

    // words queued or still in the pipeline must fit in the result queue
    assign used = 5'(q_count) + 5'(d_vld) + 5'(addr_occ) + 5'(res_vld);
    assign i_in.ready = !clearing && (used < 5'(ppi_pkg::OUTQ_DEPTH));
    assign accept = i_in.valid && i_in.ready;

    // decode and packet tracking
    ppi_decode #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_accept    (accept),
        .i_operation (i_in.operation),
        .i_word      (i_in.word),
        .i_pixel_x   (i_in.pixel_x),
        .i_pixel_y   (i_in.pixel_y),
        .o_vld       (d_vld),
        .o_item      (d_item)
    );

    // pixel address
    ppi_addr #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS),
        .PIX_AW     (PIX_AW)
    ) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (d_vld),
        .i_item     (d_item),
        .o_vld      (c_vld),
        .o_item     (c_item),
        .o_pix_addr (c_pix_addr),
        .o_occ      (addr_occ)
    );

    // memories and read-modify-write
    ppi_store #(
        .IMAGE_COLS  (IMAGE_COLS),
        .IMAGE_ROWS  (IMAGE_ROWS),
        .NUM_SOURCES (NUM_SOURCES),
        .PIX_AW      (PIX_AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (c_vld),
        .i_item     (c_item),
        .i_pix_addr (c_pix_addr),
        .o_clearing (clearing),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // result queue
    assign pop = o_out.valid && o_out.ready;

    ppi_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // output word
    assign o_out.valid               = q_valid;
    assign o_out.frame_checked       = q_data.frame_checked;
    assign o_out.frame_missed        = q_data.frame_missed;
    assign o_out.source_id           = q_data.source_id;
    assign o_out.expected_frame      = q_data.expected_frame;
    assign o_out.received_frame      = q_data.received_frame;
    assign o_out.source_out_of_range = q_data.source_out_of_range;
    assign o_out.packet_too_long     = q_data.packet_too_long;
    assign o_out.packet_ended_short  = q_data.packet_ended_short;
    assign o_out.pixel_count         = q_data.pixel_count;

endmodule

// File: design/ppi_decode.sv
// ------------------------------------------------------------------------
// ppi_decode
// word classifier, packet tracker and length limit register
// ------------------------------------------------------------------------
module ppi_decode #(
    parameter int NUM_SOURCES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppi_cfg_if.sink         i_cfg,
    input  logic            i_accept,
    input  logic            i_operation,
    input  logic [63:0]     i_word,
    input  logic [6:0]      i_pixel_x,
    input  logic [6:0]      i_pixel_y,
    output logic            o_vld,
    output ppi_pkg::t_item  o_item
);

    localparam logic [8:0] SRC_LIMIT = 9'(NUM_SOURCES);

    logic [7:0]     start_byte;
    logic [7:0]     id_byte;
    logic           r_in_packet;
    logic           n_in_packet;
    logic [9:0]     r_word_cnt;
    logic [9:0]     n_word_cnt;
    logic [9:0]     r_max_words;
    logic           r_vld;
    ppi_pkg::t_item r_item;
    ppi_pkg::t_item n_item;

    assign start_byte = i_word[63:56];
    assign id_byte    = i_word[55:48];

    // limit register takes every write
    assign i_cfg.ready = 1'b1;

    // classify the word and work out the packet state after it
    always_comb begin
        n_in_packet = r_in_packet;
        n_word_cnt  = r_word_cnt;
        n_item      = '0;
        n_item.kind = ppi_pkg::K_IGNORE;
        priority if (i_operation) begin
            n_item.kind = ppi_pkg::K_READ;
            n_item.x    = {3'b000, i_pixel_x};
            n_item.y    = {3'b000, i_pixel_y};
        end else if (start_byte == ppi_pkg::HDR_START) begin
            n_item.kind      = ppi_pkg::K_HEADER;
            n_item.source_id = id_byte;
            n_item.frame     = i_word[47:36];
            n_item.src_oor   = ({1'b0, id_byte} >= SRC_LIMIT);
            n_in_packet      = 1'b1;
            n_word_cnt       = 10'd1;
        end else if (r_in_packet) begin
            if (start_byte == ppi_pkg::SHORT_START && id_byte == ppi_pkg::SHORT_ID) begin
                n_item.kind = ppi_pkg::K_SHORT;
                n_in_packet = 1'b0;
                n_word_cnt  = '0;
            end else begin
                n_item.kind = ppi_pkg::K_PHOTON;
                n_item.x    = i_word[63:54];
                n_item.y    = i_word[53:44];
                if (r_word_cnt < ppi_pkg::COUNT_MAX) begin
                    n_word_cnt = r_word_cnt + 10'd1;
                end
                n_item.too_long = (n_word_cnt > r_max_words);
            end
        end else begin
            // stray word outside a packet
            n_item.kind = ppi_pkg::K_IGNORE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_word_cnt  <= '0;
            r_max_words <= ppi_pkg::MAX_WORDS_RESET;
            r_vld       <= 1'b0;
        end else begin
            r_vld <= i_accept;
            if (i_accept) begin
                r_in_packet <= n_in_packet;
                r_word_cnt  <= n_word_cnt;
            end
            if (i_cfg.valid) begin
                r_max_words <= i_cfg.max_packet_words;
            end
        end
    end

    // decoded word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: design/ppi_addr.sv
// ------------------------------------------------------------------------
// ppi_addr
// pixel address pipeline: coordinate wrap in two stages, then linear index
// ------------------------------------------------------------------------
module ppi_addr #(
    parameter int IMAGE_COLS = 80,
    parameter int IMAGE_ROWS = 125,
    parameter int PIX_AW     = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  ppi_pkg::t_item    i_item,
    output logic              o_vld,
    output ppi_pkg::t_item    o_item,
    output logic [PIX_AW-1:0] o_pix_addr,
    output logic [1:0]        o_occ
);

    localparam logic [10:0] COLS_D = 11'(IMAGE_COLS);
    localparam logic [10:0] ROWS_D = 11'(IMAGE_ROWS);

    // restoring remainder over the shift positions hi down to lo
    function automatic logic [9:0] rem_steps(input logic [9:0] v, input logic [10:0] d,
                                             input int hi, input int lo);
        logic [9:0]  r;
        logic [20:0] t;
        r = v;
        for (int k = 9; k >= 0; k--) begin
            t = 21'(d) << k;
            if (k <= hi && k >= lo && 21'(r) >= t) begin
                r = r - t[9:0];
            end
        end
        return r;
    endfunction

    logic           r_a_vld;
    logic           r_b_vld;
    logic           r_c_vld;
    ppi_pkg::t_item a_item;
    ppi_pkg::t_item b_item;
    ppi_pkg::t_item r_a_item;
    ppi_pkg::t_item r_b_item;
    ppi_pkg::t_item r_c_item;
    logic [20:0]    lin;
    logic [PIX_AW-1:0] r_c_addr;

    // upper half of the wrap
    always_comb begin
        a_item   = i_item;
        a_item.x = rem_steps(i_item.x, COLS_D, 9, 5);
        a_item.y = rem_steps(i_item.y, ROWS_D, 9, 5);
    end

    // lower half of the wrap
    always_comb begin
        b_item   = r_a_item;
        b_item.x = rem_steps(r_a_item.x, COLS_D, 4, 0);
        b_item.y = rem_steps(r_a_item.y, ROWS_D, 4, 0);
    end

    // column-major linear index
    assign lin = 21'(r_b_item.x) * 21'(ROWS_D) + 21'(r_b_item.y);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_a_item <= a_item;
        r_b_item <= b_item;
        r_c_item <= r_b_item;
        r_c_addr <= lin[PIX_AW-1:0];
    end

    assign o_vld      = r_c_vld;
    assign o_item     = r_c_item;
    assign o_pix_addr = r_c_addr;
    assign o_occ      = {1'b0, r_a_vld} + {1'b0, r_b_vld} + {1'b0, r_c_vld};

endmodule

// File: design/ppi_store.sv
// ------------------------------------------------------------------------
// ppi_store
// pixel counter and expected frame memories with read-modify-write
// ------------------------------------------------------------------------
`include "photon_packet_imager_core_defines.svh"

module ppi_store #(
    parameter int IMAGE_COLS  = 80,
    parameter int IMAGE_ROWS  = 125,
    parameter int NUM_SOURCES = 16,
    parameter int PIX_AW      = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  ppi_pkg::t_item    i_item,
    input  logic [PIX_AW-1:0] i_pix_addr,
    output logic              o_clearing,
    output logic              o_res_vld,
    output ppi_pkg::t_result  o_res
);

    localparam int PIX_DEPTH = IMAGE_COLS * IMAGE_ROWS;
    localparam int SRC_AW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CLEAR_LEN = (PIX_DEPTH > NUM_SOURCES) ? PIX_DEPTH : NUM_SOURCES;
    localparam int CLR_AW    = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
    localparam logic [CLR_AW-1:0] LAST_IDX   = CLR_AW'(CLEAR_LEN - 1);
    localparam logic [CLR_AW:0]   PIX_DEPTH_C = (CLR_AW + 1)'(PIX_DEPTH);
    localparam logic [CLR_AW:0]   SRC_DEPTH_C = (CLR_AW + 1)'(NUM_SOURCES);

    logic [15:0]       pix_mem [PIX_DEPTH];
    logic [11:0]       frm_mem [NUM_SOURCES];

    logic              r_clearing;
    logic [CLR_AW-1:0] r_clr_idx;

    logic [SRC_AW-1:0] src_addr;
    logic [15:0]       r_pix_q;
    logic [11:0]       r_frm_q;
    logic              r_m_vld;
    ppi_pkg::t_item    r_m_item;
    logic [PIX_AW-1:0] r_m_pix_addr;
    logic [SRC_AW-1:0] r_m_src_addr;

    logic              r_fw_pix_en;
    logic [PIX_AW-1:0] r_fw_pix_addr;
    logic [15:0]       r_fw_pix_data;
    logic              r_fw_frm_en;
    logic [SRC_AW-1:0] r_fw_frm_addr;
    logic [11:0]       r_fw_frm_data;

    logic [15:0]       pix_old;
    logic [11:0]       frm_old;
    logic              rmw_pix_we;
    logic [15:0]       rmw_pix_wd;
    logic              rmw_frm_we;
    logic [11:0]       rmw_frm_wd;

    logic              pix_we;
    logic [PIX_AW-1:0] pix_wa;
    logic [15:0]       pix_wd;
    logic              frm_we;
    logic [SRC_AW-1:0] frm_wa;
    logic [11:0]       frm_wd;

    ppi_pkg::t_result  res;

    // frame table address, parked at zero for ids beyond the table
    assign src_addr = i_item.src_oor ? '0 : i_item.source_id[SRC_AW-1:0];

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // old values, bypassing the write that landed with our read
    assign pix_old = (r_fw_pix_en && r_fw_pix_addr == r_m_pix_addr) ? r_fw_pix_data : r_pix_q;
    assign frm_old = (r_fw_frm_en && r_fw_frm_addr == r_m_src_addr) ? r_fw_frm_data : r_frm_q;

    // modify
    always_comb begin
        rmw_pix_we = r_m_vld && (r_m_item.kind == ppi_pkg::K_READ ||
                                 r_m_item.kind == ppi_pkg::K_PHOTON);
        rmw_pix_wd = (r_m_item.kind == ppi_pkg::K_READ) ? 16'd0 : pix_old + 16'd1;
        rmw_frm_we = r_m_vld && r_m_item.kind == ppi_pkg::K_HEADER && !r_m_item.src_oor;
        rmw_frm_wd = frm_old + 12'd1;
    end

    // write port select: clearing pass or write-back
    always_comb begin
        if (r_clearing) begin
            pix_we = ({1'b0, r_clr_idx} < PIX_DEPTH_C);
            pix_wa = r_clr_idx[PIX_AW-1:0];
            pix_wd = '0;
            frm_we = ({1'b0, r_clr_idx} < SRC_DEPTH_C);
            frm_wa = r_clr_idx[SRC_AW-1:0];
            frm_wd = '0;
        end else begin
            pix_we = rmw_pix_we;
            pix_wa = r_m_pix_addr;
            pix_wd = rmw_pix_wd;
            frm_we = rmw_frm_we;
            frm_wa = r_m_src_addr;
            frm_wd = rmw_frm_wd;
        end
    end

    // pixel counter memory
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            pix_mem[pix_wa] <= pix_wd;
        end
        r_pix_q <= pix_mem[i_pix_addr];
    end

    // expected frame memory
    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            frm_mem[frm_wa] <= frm_wd;
        end
        r_frm_q <= frm_mem[src_addr];
    end

    // modify stage control and bypass valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld     <= 1'b0;
            r_fw_pix_en <= 1'b0;
            r_fw_frm_en <= 1'b0;
        end else begin
            r_m_vld     <= i_vld;
            r_fw_pix_en <= rmw_pix_we;
            r_fw_frm_en <= rmw_frm_we;
        end
    end

    // modify stage payload and bypass data
    always_ff @(posedge i_clk) begin
        r_m_item     <= i_item;
        r_m_pix_addr <= i_pix_addr;
        r_m_src_addr <= src_addr;
        if (rmw_pix_we) begin
            r_fw_pix_addr <= r_m_pix_addr;
            r_fw_pix_data <= rmw_pix_wd;
        end
        if (rmw_frm_we) begin
            r_fw_frm_addr <= r_m_src_addr;
            r_fw_frm_data <= rmw_frm_wd;
        end
    end

    // result word
    always_comb begin
        res = '0;
        unique case (r_m_item.kind)
            ppi_pkg::K_READ: begin
                res.pixel_count = pix_old;
            end
            ppi_pkg::K_HEADER: begin
                res.source_id      = r_m_item.source_id;
                res.received_frame = r_m_item.frame;
                if (r_m_item.src_oor) begin
                    res.source_out_of_range = 1'b1;
                end else begin
                    res.frame_checked  = 1'b1;
                    res.frame_missed   = (frm_old != r_m_item.frame);
                    res.expected_frame = frm_old;
                end
            end
            ppi_pkg::K_PHOTON: begin
                res.packet_too_long = r_m_item.too_long;
            end
            ppi_pkg::K_SHORT: begin
                res.packet_ended_short = 1'b1;
            end
            ppi_pkg::K_IGNORE: begin
                res = '0;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign o_clearing = r_clearing;
    assign o_res_vld  = r_m_vld;
    assign o_res      = res;

    // checks
    `PPI_ASSERT_IMP(a_idle_while_clearing, i_clk, i_rst_n, r_clearing, !i_vld && !r_m_vld, "word in flight during clearing pass")
    `PPI_ASSERT_NXT(a_read_clears, i_clk, i_rst_n, r_m_vld && r_m_item.kind == ppi_pkg::K_READ, r_fw_pix_en && r_fw_pix_data == 16'd0, "read did not clear pixel")
    `PPI_ASSERT_NXT(a_frame_advance, i_clk, i_rst_n, rmw_frm_we, r_fw_frm_en && r_fw_frm_data == $past(frm_old) + 12'd1, "expected frame did not advance")

endmodule

// File: design/ppi_out_fifo.sv
// ------------------------------------------------------------------------
// ppi_out_fifo
// result queue between the write-back stage and the output channel
// ------------------------------------------------------------------------
`include "photon_packet_imager_core_defines.svh"

module ppi_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ppi_pkg::t_result              i_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output ppi_pkg::t_result              o_data,
    output logic [ppi_pkg::OUTQ_CW-1:0]   o_count
);

    localparam logic [ppi_pkg::OUTQ_CW-1:0] FULL = ppi_pkg::OUTQ_CW'(ppi_pkg::OUTQ_DEPTH);

    ppi_pkg::t_result                r_mem [ppi_pkg::OUTQ_DEPTH];
    logic [ppi_pkg::OUTQ_AW-1:0]     r_wr_ptr;
    logic [ppi_pkg::OUTQ_AW-1:0]     r_rd_ptr;
    logic [ppi_pkg::OUTQ_CW-1:0]     r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // checks
    `PPI_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_count != FULL || i_pop, "result queue overflow")

endmodule
